// ----- design/sdiv_pkg.sv -----
// ----------------------------------------------------------------------------
// sdiv_pkg
// shared constants and types of the pipelined signed divider
// ----------------------------------------------------------------------------
package sdiv_pkg;

    // default operand width
    localparam int DATA_WIDTH_DEFAULT = 32;

    // sign and special-case bits that travel with each item down the pipe
    typedef struct packed {
        logic a_neg;  // dividend was negative, sets remainder sign
        logic q_neg;  // operand signs differ, sets quotient sign
        logic zero;   // divisor was zero
    } t_sign_flags;

endpackage

// ----- design/sdiv_if.sv -----
// ----------------------------------------------------------------------------
// sdiv channel interfaces
// valid/ready channels for operand pairs and for results
// ----------------------------------------------------------------------------
interface sdiv_in_if #(
    parameter int DATA_WIDTH = sdiv_pkg::DATA_WIDTH_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] dividend;
    logic signed [DATA_WIDTH-1:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface sdiv_out_if #(
    parameter int DATA_WIDTH = sdiv_pkg::DATA_WIDTH_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] quotient;
    logic signed [DATA_WIDTH-1:0] remainder;
    logic                         divide_by_zero;

    modport source (output valid, output quotient, output remainder,
                    output divide_by_zero, input ready);
    modport sink   (input valid, input quotient, input remainder,
                    input divide_by_zero, output ready);
endinterface

// ----- design/signed_int_divider_with_remainder_top.sv -----
// ----------------------------------------------------------------------------
// signed_int_divider_with_remainder_top
// fully pipelined signed restoring divider, quotient and remainder
// ----------------------------------------------------------------------------
// The divider takes one operand pair per cycle while input ready is high
// and returns one result per pair, in order. One register stage takes the
// operand magnitudes, DATA_WIDTH stages each produce one quotient bit with
// one subtract/compare, and the last stage restores the signs into the
// output register. The quotient truncates toward zero and the remainder
// takes the sign of the dividend. A zero divisor returns quotient 0,
// remainder 0 and raises divide_by_zero; the most negative dividend over
// minus one wraps to the most negative quotient with remainder 0. A skid
// register behind the output register lets the input keep taking transfers
// while a finished result waits; once both hold a result the whole pipe
// holds and input ready drops.
// ----------------------------------------------------------------------------
module signed_int_divider_with_remainder_top #(
    parameter int DATA_WIDTH = sdiv_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdiv_in_if.sink    i_in,
    sdiv_out_if.source o_out
);
    import sdiv_pkg::*;

    localparam int W = DATA_WIDTH;

    // pipeline stage registers, stage 0 holds magnitudes, stage k holds
    // the state after k quotient bits
    logic                r_v   [W+1];
    logic [W-1:0]        r_rem [W+1];  // partial remainder
    logic [W-1:0]        r_dvd [W+1];  // dividend bits left, quotient bits in
    logic [W-1:0]        r_ub  [W+1];  // divisor magnitude
    t_sign_flags         r_flg [W+1];

    logic [W-1:0]        n_rem [W+1];
    logic [W-1:0]        n_dvd [W+1];

    // per-step trial subtract
    logic [W-1:0]        w_shift [W];
    logic [W:0]          w_diff  [W];

    // stage 0 inputs
    logic [W-1:0]        n_a_mag;
    logic [W-1:0]        n_b_mag;
    t_sign_flags         n_flg0;

    // sign restore
    logic [W-1:0]        w_quo;
    logic [W-1:0]        w_rem;
    logic [W-1:0]        n_res_quo;
    logic [W-1:0]        n_res_rem;

    // output and skid registers
    logic                r_out_valid;
    logic [W-1:0]        r_out_quo;
    logic [W-1:0]        r_out_rem;
    logic                r_out_dbz;
    logic                r_skid_valid;
    logic [W-1:0]        r_skid_quo;
    logic [W-1:0]        r_skid_rem;
    logic                r_skid_dbz;

    logic                pipe_en;
    logic                pipe_take;
    logic                out_free;

    // whole pipe moves unless the skid register is occupied
    assign pipe_en   = !r_skid_valid;
    assign pipe_take = pipe_en && r_v[W];
    assign out_free  = !r_out_valid || o_out.ready;

    // no input transfer while reset is held
    assign i_in.ready = pipe_en && i_rst_n;

    // operand magnitudes and signs
    always_comb begin
        n_a_mag = i_in.dividend[W-1] ? (~i_in.dividend + W'(1)) : i_in.dividend;
        n_b_mag = i_in.divisor[W-1]  ? (~i_in.divisor + W'(1))  : i_in.divisor;
        n_flg0.a_neg = i_in.dividend[W-1];
        n_flg0.q_neg = i_in.dividend[W-1] ^ i_in.divisor[W-1];
        n_flg0.zero  = (i_in.divisor == '0);
    end

    // one restoring step per stage
    always_comb begin
        n_rem[0] = '0;
        n_dvd[0] = n_a_mag;
        for (int k = 0; k < W; k++) begin
            w_shift[k] = {r_rem[k][W-2:0], r_dvd[k][W-1]};
            w_diff[k]  = {1'b0, w_shift[k]} - {1'b0, r_ub[k]};
            // no borrow: trial subtract fits, quotient bit is one
            n_rem[k+1] = w_diff[k][W] ? w_shift[k] : w_diff[k][W-1:0];
            n_dvd[k+1] = {r_dvd[k][W-2:0], !w_diff[k][W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_rem[0] <= n_rem[0];
            r_dvd[0] <= n_dvd[0];
            r_ub[0]  <= n_b_mag;
            r_flg[0] <= n_flg0;
            for (int k = 0; k < W; k++) begin
                r_rem[k+1] <= n_rem[k+1];
                r_dvd[k+1] <= n_dvd[k+1];
                r_ub[k+1]  <= r_ub[k];
                r_flg[k+1] <= r_flg[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= W; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (pipe_en) begin
            r_v[0] <= i_in.valid;
            for (int k = 0; k < W; k++) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    // sign restore, zero divisor forces both results to zero
    always_comb begin
        w_quo = r_dvd[W];
        w_rem = r_rem[W];
        if (r_flg[W].zero) begin
            n_res_quo = '0;
            n_res_rem = '0;
        end else begin
            n_res_quo = r_flg[W].q_neg ? (~w_quo + W'(1)) : w_quo;
            n_res_rem = r_flg[W].a_neg ? (~w_rem + W'(1)) : w_rem;
        end
    end

    // output register with skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= pipe_take;
            end
        end else if (pipe_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_quo <= r_skid_quo;
                r_out_rem <= r_skid_rem;
                r_out_dbz <= r_skid_dbz;
            end else begin
                r_out_quo <= n_res_quo;
                r_out_rem <= n_res_rem;
                r_out_dbz <= r_flg[W].zero;
            end
        end else if (pipe_take) begin
            r_skid_quo <= n_res_quo;
            r_skid_rem <= n_res_rem;
            r_skid_dbz <= r_flg[W].zero;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.quotient       = r_out_quo;
    assign o_out.remainder      = r_out_rem;
    assign o_out.divide_by_zero = r_out_dbz;

endmodule
